### hdl/assert_macros.svh
// Assertion macros shared by the grouped FIFO queue modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that holds at every clock edge outside reset.
`define GFQ_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// A consequence that holds in the same cycle as its trigger.
`define GFQ_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// A consequence that holds in the cycle after its trigger.
`define GFQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/gfq_pkg.sv
// Shared types, codes and widths of the grouped FIFO queue.
package gfq_pkg;

    localparam int CMD_W    = 1;
    localparam int VALUE_W  = 20;
    localparam int GROUP_W  = 4;
    localparam int STATUS_W = 2;

    localparam int NUM_GROUPS_DEF  = 16;
    localparam int GROUP_DEPTH_DEF = 16;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH = 1'b0,
        CMD_POP  = 1'b1
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_PUSHED  = 2'd0,
        ST_POPPED  = 2'd1,
        ST_EMPTY   = 2'd2,
        ST_DROPPED = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_POP_ADDR,
        S_POP_DONE
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear_en;
        logic accept;
        logic push_commit;
        logic empty_commit;
        logic pop_meta_rd;
        logic pop_data_rd;
        logic pop_commit;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_pop;
        logic order_empty;
        logic out_free;
        logic clear_last;
    } t_dp_status;

endpackage

### hdl/gfq_if.sv
// Request and response channel interfaces of the grouped FIFO queue.
interface gfq_req_if;
    import gfq_pkg::*;

    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   cmd;
    logic [VALUE_W-1:0] elem_value;
    logic [GROUP_W-1:0] group_id;

    modport source (output valid, cmd, elem_value, group_id, input ready);
    modport sink   (input valid, cmd, elem_value, group_id, output ready);
endinterface

interface gfq_rsp_if;
    import gfq_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [VALUE_W-1:0]  popped_value;
    logic [GROUP_W-1:0]  popped_group;

    modport source (output valid, status, popped_value, popped_group, input ready);
    modport sink   (input valid, status, popped_value, popped_group, output ready);
endinterface

### hdl/grouped_fifo_queue.sv
// Top level of the grouped FIFO queue: controller, datapath and channel wiring.
// Sequencing: one request is in flight at a time. A push or a pop on an empty queue
// loads its result in the execute step after acceptance; a pop of an element reads the
// order queue, then the group head and count, then the element store, before its result
// is loaded. A new request is taken only once the last one has finished its final step.
// Reset: synchronous, active low; a clearing pass over all NUM_GROUPS groups follows.
module grouped_fifo_queue #(
    parameter int NUM_GROUPS  = gfq_pkg::NUM_GROUPS_DEF,
    parameter int GROUP_DEPTH = gfq_pkg::GROUP_DEPTH_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    gfq_req_if.sink  i_req,
    gfq_rsp_if.source o_rsp
);
    import gfq_pkg::*;

    // The controller decides which step each cycle performs; the datapath owns
    // every memory, the order queue pointers and the result register. They
    // talk only through the command and status structs below.
    t_dp_cmd    w_cmd;
    t_dp_status w_status;
    logic       w_in_ready;

    // The controller raises ready only between requests. A request that
    // arrives while the previous result still waits in the output register is
    // accepted anyway; only the final step of that request waits for the
    // output register to drain. The clearing pass after reset zeroes every
    // group head and count, and no request is accepted until it is done.
    gfq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (w_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    assign i_req.ready = w_in_ready;

    // The datapath keeps each group as a circular FIFO inside one element
    // store addressed by group and slot. A group enters the order queue on
    // its first push and leaves it when its last element is popped, so the
    // front of the order queue always names the group to serve next.
    gfq_dp #(
        .NUM_GROUPS  (NUM_GROUPS),
        .GROUP_DEPTH (GROUP_DEPTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .i_req_cmd      (i_req.cmd),
        .i_elem_value   (i_req.elem_value),
        .i_group_id     (i_req.group_id),
        .i_out_ready    (o_rsp.ready),
        .o_out_valid    (o_rsp.valid),
        .o_out_status   (o_rsp.status),
        .o_popped_value (o_rsp.popped_value),
        .o_popped_group (o_rsp.popped_group)
    );

endmodule

### hdl/gfq_ctrl.sv
// Sequencing state machine of the grouped FIFO queue.
`include "assert_macros.svh"

module gfq_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  gfq_pkg::t_dp_status i_status,
    output gfq_pkg::t_dp_cmd    o_cmd
);
    import gfq_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (i_status.clear_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) n_state = S_EXEC;
            end
            S_EXEC: begin
                if (i_status.is_pop && !i_status.order_empty) begin
                    n_state = S_POP_ADDR;
                end else if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_POP_ADDR: begin
                n_state = S_POP_DONE;
            end
            S_POP_DONE: begin
                if (i_status.out_free) n_state = S_IDLE;
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear_en = 1'b1;
            end
            S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            S_EXEC: begin
                if (!i_status.is_pop) begin
                    o_cmd.push_commit = i_status.out_free;
                end else if (i_status.order_empty) begin
                    o_cmd.empty_commit = i_status.out_free;
                end else begin
                    o_cmd.pop_meta_rd = 1'b1;
                end
            end
            S_POP_ADDR: begin
                o_cmd.pop_data_rd = 1'b1;
            end
            S_POP_DONE: begin
                o_cmd.pop_commit = i_status.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    `GFQ_ASSERT_NEXT(a_accept_exec, o_cmd.accept, r_state == S_EXEC, "accepted request did not start")
    `GFQ_ASSERT_ALWAYS(a_one_write, $onehot0({o_cmd.push_commit, o_cmd.pop_commit, o_cmd.empty_commit, o_cmd.clear_en}), "more than one state update in a cycle")
    `GFQ_ASSERT_IMPL(a_commit_free, o_cmd.push_commit || o_cmd.pop_commit || o_cmd.empty_commit, i_status.out_free, "result loaded into an occupied output register")

endmodule

### hdl/gfq_dp.sv
// Datapath of the grouped FIFO queue: group memories, order queue and result register.
`include "assert_macros.svh"

module gfq_dp #(
    parameter int NUM_GROUPS  = gfq_pkg::NUM_GROUPS_DEF,
    parameter int GROUP_DEPTH = gfq_pkg::GROUP_DEPTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  gfq_pkg::t_dp_cmd             i_cmd,
    output gfq_pkg::t_dp_status          o_status,
    input  logic [gfq_pkg::CMD_W-1:0]    i_req_cmd,
    input  logic [gfq_pkg::VALUE_W-1:0]  i_elem_value,
    input  logic [gfq_pkg::GROUP_W-1:0]  i_group_id,
    input  logic                         i_out_ready,
    output logic                         o_out_valid,
    output logic [gfq_pkg::STATUS_W-1:0] o_out_status,
    output logic [gfq_pkg::VALUE_W-1:0]  o_popped_value,
    output logic [gfq_pkg::GROUP_W-1:0]  o_popped_group
);
    import gfq_pkg::*;

    localparam int GW  = $clog2(NUM_GROUPS);
    localparam int HW  = $clog2(GROUP_DEPTH);
    localparam int CW  = $clog2(GROUP_DEPTH + 1);
    localparam int OCW = $clog2(NUM_GROUPS + 1);
    localparam int MW  = HW + CW;
    localparam int AW  = GW + HW;
    localparam int SD  = NUM_GROUPS * (2 ** HW);

    localparam logic [HW:0]    DEPTH_W = (HW + 1)'(GROUP_DEPTH);
    localparam logic [GW:0]    NGRP_W  = (GW + 1)'(NUM_GROUPS);
    localparam logic [CW-1:0]  DEPTH_C = CW'(GROUP_DEPTH);
    localparam logic [OCW-1:0] NGRP_C  = OCW'(NUM_GROUPS);
    localparam logic [GW-1:0]  LAST_G  = GW'(NUM_GROUPS - 1);

    // Per-group head and count, the order queue and the element store.
    logic [MW-1:0]      r_meta_mem  [NUM_GROUPS];
    logic [GW-1:0]      r_order_mem [NUM_GROUPS];
    logic [VALUE_W-1:0] r_store_mem [SD];

    logic [MW-1:0]      r_meta_q;
    logic [GW-1:0]      r_order_q;
    logic [VALUE_W-1:0] r_store_q;

    t_cmd               r_cmd;
    logic [VALUE_W-1:0] r_value;
    logic [GW-1:0]      r_grp;
    logic               r_grp_ok;
    logic [GW-1:0]      r_pop_grp;

    logic [GW-1:0]      r_order_head;
    logic [OCW-1:0]     r_order_count;
    logic [GW-1:0]      r_clr_idx;

    logic               r_out_valid;
    t_status            r_out_status;
    logic [VALUE_W-1:0] r_out_value;
    logic [GROUP_W-1:0] r_out_group;

    logic [HW-1:0] w_head;
    logic [CW-1:0] w_count;
    logic          w_push_drop;
    logic [HW:0]   w_slot_sum;
    logic [HW-1:0] w_slot;
    logic          w_order_new;
    logic [GW:0]   w_ord_sum;
    logic [GW-1:0] w_ord_slot;
    logic [HW:0]   w_head_inc;
    logic [HW-1:0] w_head_next;
    logic [CW-1:0] w_count_dec;
    logic          w_group_done;
    logic [GW:0]   w_ohead_inc;
    logic [GW-1:0] w_ohead_next;
    logic          w_push_ok;
    logic          w_out_free;

    logic          w_meta_we;
    logic [GW-1:0] w_meta_waddr;
    logic [MW-1:0] w_meta_wdata;
    logic          w_meta_re;
    logic [GW-1:0] w_meta_raddr;

    assign w_head  = r_meta_q[MW-1:CW];
    assign w_count = r_meta_q[CW-1:0];

    // Push: place the element behind the waiting ones of its group.
    assign w_push_drop = !r_grp_ok || (w_count >= DEPTH_C);
    assign w_push_ok   = i_cmd.push_commit && !w_push_drop;
    assign w_slot_sum  = (HW + 1)'(w_head) + (HW + 1)'(w_count);
    assign w_slot      = (w_slot_sum >= DEPTH_W) ? HW'(w_slot_sum - DEPTH_W) : HW'(w_slot_sum);
    assign w_order_new = (w_count == '0) && (r_order_count < NGRP_C);
    assign w_ord_sum   = (GW + 1)'(r_order_head) + (GW + 1)'(r_order_count);
    assign w_ord_slot  = (w_ord_sum >= NGRP_W) ? GW'(w_ord_sum - NGRP_W) : GW'(w_ord_sum);

    // Pop: advance the group head and retire the group when it runs empty.
    assign w_head_inc   = (HW + 1)'(w_head) + (HW + 1)'(1);
    assign w_head_next  = (w_head_inc >= DEPTH_W) ? '0 : HW'(w_head_inc);
    assign w_count_dec  = (w_count != '0) ? (w_count - CW'(1)) : w_count;
    assign w_group_done = (w_count_dec == '0);
    assign w_ohead_inc  = (GW + 1)'(r_order_head) + (GW + 1)'(1);
    assign w_ohead_next = (w_ohead_inc >= NGRP_W) ? '0 : GW'(w_ohead_inc);

    always_comb begin
        w_meta_we    = 1'b0;
        w_meta_waddr = r_clr_idx;
        w_meta_wdata = '0;
        if (i_cmd.clear_en) begin
            w_meta_we = 1'b1;
        end else if (w_push_ok) begin
            w_meta_we    = 1'b1;
            w_meta_waddr = r_grp;
            w_meta_wdata = {w_head, w_count + CW'(1)};
        end else if (i_cmd.pop_commit) begin
            w_meta_we    = 1'b1;
            w_meta_waddr = r_pop_grp;
            w_meta_wdata = {w_head_next, w_count_dec};
        end
    end

    assign w_meta_re    = i_cmd.accept || i_cmd.pop_meta_rd;
    assign w_meta_raddr = i_cmd.accept ? GW'(i_group_id) : r_order_q;

    always_ff @(posedge i_clk) begin
        if (w_meta_we) r_meta_mem[w_meta_waddr] <= w_meta_wdata;
        if (w_meta_re) r_meta_q <= r_meta_mem[w_meta_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (w_push_ok && w_order_new) r_order_mem[w_ord_slot] <= r_grp;
        if (i_cmd.accept) r_order_q <= r_order_mem[r_order_head];
    end

    always_ff @(posedge i_clk) begin
        if (w_push_ok) r_store_mem[AW'({r_grp, w_slot})] <= r_value;
        if (i_cmd.pop_data_rd) r_store_q <= r_store_mem[AW'({r_pop_grp, w_head})];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_cmd    <= t_cmd'(i_req_cmd);
            r_value  <= i_elem_value;
            r_grp    <= GW'(i_group_id);
            r_grp_ok <= (32'(i_group_id) < NUM_GROUPS);
        end
        if (i_cmd.pop_meta_rd) r_pop_grp <= r_order_q;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order_head  <= '0;
            r_order_count <= '0;
            r_clr_idx     <= '0;
        end else begin
            if (i_cmd.clear_en) r_clr_idx <= r_clr_idx + GW'(1);
            if (w_push_ok && w_order_new) begin
                r_order_count <= r_order_count + OCW'(1);
            end else if (i_cmd.pop_commit && w_group_done) begin
                r_order_head  <= w_ohead_next;
                r_order_count <= r_order_count - OCW'(1);
            end
        end
    end

    // Result register; a new request may arrive while a result waits here.
    assign w_out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.push_commit || i_cmd.pop_commit || i_cmd.empty_commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push_commit) begin
            r_out_status <= w_push_drop ? ST_DROPPED : ST_PUSHED;
            r_out_value  <= '0;
            r_out_group  <= '0;
        end else if (i_cmd.empty_commit) begin
            r_out_status <= ST_EMPTY;
            r_out_value  <= '0;
            r_out_group  <= '0;
        end else if (i_cmd.pop_commit) begin
            r_out_status <= ST_POPPED;
            r_out_value  <= r_store_q;
            r_out_group  <= GROUP_W'(r_pop_grp);
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_out_status   = r_out_status;
    assign o_popped_value = r_out_value;
    assign o_popped_group = r_out_group;

    assign o_status.is_pop      = (r_cmd == CMD_POP);
    assign o_status.order_empty = (r_order_count == '0);
    assign o_status.out_free    = w_out_free;
    assign o_status.clear_last  = (r_clr_idx == LAST_G);

    `GFQ_ASSERT_ALWAYS(a_order_bound, r_order_count <= NGRP_C, "order queue holds more groups than exist")
    `GFQ_ASSERT_NEXT(a_order_grow, w_push_ok && w_order_new, r_order_count == OCW'($past(r_order_count) + OCW'(1)), "new group not added to order queue")
    `GFQ_ASSERT_IMPL(a_clear_quiet, i_cmd.clear_en, !r_out_valid, "result pending during clearing pass")

endmodule

### dv/grouped_fifo_queue_test.sv
// Self-checking testbench of the grouped FIFO queue, with its own model of the group queues.
`timescale 1ns / 1ps

module grouped_fifo_queue_test;
    import gfq_pkg::*;

    localparam int NUM_GROUPS  = NUM_GROUPS_DEF;
    localparam int GROUP_DEPTH = GROUP_DEPTH_DEF;

    // The longest correct quiet spell is a few receiver stalls long.
    // This bound is many times that and ends a hung run.
    localparam int STALL_LIMIT = 4000;

    // Cycles to wait after the last result, past the longest pop latency.
    localparam int TAIL_CYCLES = 10;

    localparam logic [VALUE_W-1:0] VALUE_MAX = {VALUE_W{1'b1}};
    localparam logic [GROUP_W-1:0] GROUP_MAX = {GROUP_W{1'b1}};

    typedef struct packed {
        t_cmd               cmd;
        logic [VALUE_W-1:0] value;
        logic [GROUP_W-1:0] group;
    } t_req;

    typedef struct packed {
        t_status            status;
        logic [VALUE_W-1:0] value;
        logic [GROUP_W-1:0] group;
    } t_rsp;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    gfq_req_if req_bus ();
    gfq_rsp_if rsp_bus ();

    grouped_fifo_queue #(
        .NUM_GROUPS  (NUM_GROUPS),
        .GROUP_DEPTH (GROUP_DEPTH)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus.sink),
        .o_rsp   (rsp_bus.source)
    );

    always #5 i_clk = ~i_clk;

    // Requests waiting for the driver, and responses the model has predicted
    // but the block has not yet returned.
    t_req pending_reqs[$];
    t_rsp expected_rsps[$];
    t_req driven_req;

    int unsigned queued_count   = 0;
    int unsigned accepted_count = 0;
    int unsigned mismatches     = 0;
    int unsigned stall_cycles   = 0;
    int unsigned send_idle_pct  = 0;
    int unsigned recv_idle_pct  = 0;

    // Model state: one circular FIFO per group plus the circular queue that
    // holds the order in which groups are served.
    logic [VALUE_W-1:0] grp_elems [NUM_GROUPS][GROUP_DEPTH];
    logic [GROUP_W-1:0] grp_head  [NUM_GROUPS];
    logic [4:0]         grp_fill  [NUM_GROUPS];
    logic [GROUP_W-1:0] order_grp [NUM_GROUPS];
    logic [GROUP_W-1:0] order_rd;
    logic [4:0]         order_fill;

    initial begin
        req_bus.valid      = 1'b0;
        req_bus.cmd        = CMD_PUSH;
        req_bus.elem_value = '0;
        req_bus.group_id   = '0;
        rsp_bus.ready      = 1'b0;
        order_rd           = '0;
        order_fill         = '0;
        for (int g = 0; g < NUM_GROUPS; g++) begin
            grp_head[g] = '0;
            grp_fill[g] = '0;
        end
    end

    // Applies one request to the model and returns the response it causes.
    function automatic t_rsp predict_response(t_req rq);
        t_rsp               rs;
        logic [GROUP_W-1:0] slot;
        logic [GROUP_W-1:0] g;
        rs = '{status: ST_PUSHED, value: '0, group: '0};
        if (rq.cmd == CMD_PUSH) begin
            if (grp_fill[rq.group] >= GROUP_DEPTH) begin
                // A full group drops the element and nothing changes.
                rs.status = ST_DROPPED;
            end else begin
                slot = grp_head[rq.group] + grp_fill[rq.group][GROUP_W-1:0];
                // A group with nothing waiting joins the back of the order queue.
                if (grp_fill[rq.group] == 0) begin
                    order_grp[order_rd + order_fill[GROUP_W-1:0]] = rq.group;
                    order_fill++;
                end
                grp_elems[rq.group][slot] = rq.value;
                grp_fill[rq.group]++;
            end
        end else if (order_fill == 0) begin
            // A pop on an empty queue reports it and changes nothing.
            rs.status = ST_EMPTY;
        end else begin
            g         = order_grp[order_rd];
            rs.status = ST_POPPED;
            rs.value  = grp_elems[g][grp_head[g]];
            rs.group  = g;
            grp_head[g]++;
            grp_fill[g]--;
            // The group leaves the order queue once its FIFO is empty.
            if (grp_fill[g] == 0) begin
                order_rd++;
                order_fill--;
            end
        end
        return rs;
    endfunction

    // Driver: a request stays on the bus until it is accepted, then the next
    // one is loaded unless the sender chooses to idle this cycle.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_bus.valid <= 1'b0;
        end else begin
            if (req_bus.valid && req_bus.ready) begin
                expected_rsps.insert(expected_rsps.size(), predict_response(driven_req));
                accepted_count++;
            end
            if (!req_bus.valid || req_bus.ready) begin
                if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    driven_req = pending_reqs[0];
                    pending_reqs.delete(0);
                    req_bus.valid      <= 1'b1;
                    req_bus.cmd        <= driven_req.cmd;
                    req_bus.elem_value <= driven_req.value;
                    req_bus.group_id   <= driven_req.group;
                end else begin
                    req_bus.valid <= 1'b0;
                end
            end
        end
    end

    // Compares one returned response with the oldest prediction.
    task automatic check_response();
        t_rsp want;
        if (expected_rsps.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: response with none expected: status %0d value %h group %0d",
                         $realtime, rsp_bus.status, rsp_bus.popped_value,
                         rsp_bus.popped_group);
        end else begin
            want = expected_rsps[0];
            expected_rsps.delete(0);
            if (rsp_bus.status !== want.status || rsp_bus.popped_value !== want.value ||
                rsp_bus.popped_group !== want.group) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: mismatch: expected status %0d value %h group %0d, got %0d %h %0d",
                             $realtime, want.status, want.value, want.group,
                             rsp_bus.status, rsp_bus.popped_value, rsp_bus.popped_group);
            end
        end
    endtask

    // Monitor: checks each accepted response and stalls the block at random.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_bus.ready <= 1'b0;
        end else begin
            if (rsp_bus.valid && rsp_bus.ready)
                check_response();
            rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Counts cycles in which neither side moves anything.
    always @(posedge i_clk) begin
        if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial begin
        while (stall_cycles < STALL_LIMIT)
            @(posedge i_clk);
        $display("== FAIL ==");
        $finish;
    end

    function automatic void add_req(t_cmd cmd, logic [VALUE_W-1:0] value,
                                    logic [GROUP_W-1:0] group);
        t_req rq;
        rq = '{cmd: cmd, value: value, group: group};
        pending_reqs.insert(pending_reqs.size(), rq);
        queued_count++;
    endfunction

    // Holds the sender back until every queued request has its response.
    task automatic wait_drained();
        while (pending_reqs.size() > 0 || accepted_count != queued_count ||
               expected_rsps.size() > 0)
            @(negedge i_clk);
    endtask

    // Random values mostly span the whole field, now and then an extreme.
    function automatic logic [VALUE_W-1:0] rand_value();
        case ($urandom_range(9))
            0: return '0;
            1: return VALUE_MAX;
            default: return VALUE_W'($urandom);
        endcase
    endfunction

    // One burst of random traffic; returns the number of requests it queued.
    // Fill bursts pile elements into a few groups, drain bursts are mostly pops
    // that work the queue down, mixed bursts spread over all groups, and noise
    // is short and fully random.
    function automatic int add_burst();
        int                 n;
        int                 kind;
        logic [GROUP_W-1:0] hot[3];
        kind = $urandom_range(9);
        n    = 0;
        for (int i = 0; i < 3; i++)
            hot[i] = GROUP_W'($urandom);
        if (kind < 3) begin
            n = $urandom_range(20, 6);
            for (int i = 0; i < n; i++)
                if ($urandom_range(9) < 8)
                    add_req(CMD_PUSH, rand_value(), hot[$urandom_range(2)]);
                else
                    add_req(CMD_POP, rand_value(), GROUP_W'($urandom));
        end else if (kind < 6) begin
            n = $urandom_range(25, 5);
            for (int i = 0; i < n; i++)
                if ($urandom_range(9) < 8)
                    add_req(CMD_POP, rand_value(), GROUP_W'($urandom));
                else
                    add_req(CMD_PUSH, rand_value(), hot[0]);
        end else if (kind < 9) begin
            n = $urandom_range(30, 10);
            for (int i = 0; i < n; i++)
                add_req($urandom_range(1) ? CMD_POP : CMD_PUSH, rand_value(),
                        GROUP_W'($urandom));
        end else begin
            n = $urandom_range(4, 1);
            for (int i = 0; i < n; i++)
                add_req($urandom_range(1) ? CMD_POP : CMD_PUSH, VALUE_W'($urandom),
                        GROUP_W'($urandom));
        end
        return n;
    endfunction

    initial begin
        int unsigned random_count;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part: empty pops, extreme values and groups, the order in
        // which groups are served, and overflow of a full group.
        add_req(CMD_POP, VALUE_MAX, GROUP_MAX);
        add_req(CMD_PUSH, '0, '0);
        add_req(CMD_PUSH, VALUE_MAX, GROUP_MAX);
        add_req(CMD_PUSH, 20'h5A5A5, '0);
        repeat (4) add_req(CMD_POP, '0, '0);
        for (int i = 0; i < GROUP_DEPTH; i++)
            add_req(CMD_PUSH, rand_value(), 4'd3);
        add_req(CMD_PUSH, 20'hA5A5A, 4'd3);
        wait_drained();

        // Random part in three phases of idling: sender light and receiver
        // heavy, then the reverse, then none. Each phase ends with the sender
        // held back until all responses have come.
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 25 : (phase == 1) ? 72 : 0;
            recv_idle_pct = (phase == 0) ? 72 : (phase == 1) ? 25 : 0;
            random_count  = 0;
            while (random_count < 334)
                random_count += add_burst();
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (mismatches == 0 && expected_rsps.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+hdl
hdl/gfq_pkg.sv
hdl/gfq_if.sv
hdl/gfq_ctrl.sv
hdl/gfq_dp.sv
hdl/grouped_fifo_queue.sv
dv/grouped_fifo_queue_test.sv
